// ===== sv/msbp_pkg.sv =====
package msbp_pkg;

	// Storage geometry
	localparam int MAX_ELEMENTS = 64;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

	// Field widths
	localparam int KEY_W      = 64;
	localparam int IDX_W      = 6;
	localparam int RANK_W     = 7;
	localparam int LRANK_W    = 6;
	localparam int MAX_RANKS  = 64;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 7;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_RANKS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_RANK = CFG_IDX_W'(1);

	typedef struct packed {
		logic [KEY_W-1:0] sort_key;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] element_index;
		logic [IDX_W-1:0] owner_rank;
		logic             local_hit;
		logic             final_item;
	} result_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIV,
		ST_RD_I,
		ST_KEY_I,
		ST_SCAN,
		ST_PLACE,
		ST_EMIT
	} state_t;

	// Key memory and rank counter control
	typedef struct packed {
		logic              key_we;
		logic [ADDR_W-1:0] key_waddr;
		logic [KEY_W-1:0]  key_wdata;
		logic [ADDR_W-1:0] key_raddr;
		logic              cap_key_i;
		logic              clr_cnt;
		logic              cmp_en;
		logic [ADDR_W-1:0] cmp_j;
		logic [ADDR_W-1:0] cur_i;
	} rank_ctl_t;

	// Order memory and emission control
	typedef struct packed {
		logic               start;
		logic [CNT_W-1:0]   n;
		logic [CNT_W-1:0]   per;
		logic [RANK_W-1:0]  rem;
		logic [LRANK_W-1:0] local_rank;
		logic               ord_we;
		logic [ADDR_W-1:0]  ord_waddr;
		logic [ADDR_W-1:0]  ord_wdata;
	} emit_ctl_t;

endpackage

// ===== sv/msbp_rank.sv =====
module msbp_rank (
	input  logic                      clk,
	input  logic                      arst_n,
	input  msbp_pkg::rank_ctl_t       ctl,
	output logic [msbp_pkg::CNT_W-1:0] rank_pos
);
	import msbp_pkg::*;

	logic [KEY_W-1:0] key_mem [MAX_ELEMENTS];
	logic [KEY_W-1:0] rd_key_q;
	logic [KEY_W-1:0] key_i_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hit;

	// Key memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_mem[ctl.key_waddr] <= ctl.key_wdata;
		end
		rd_key_q <= key_mem[ctl.key_raddr];
	end

	// Hold the key of the element being placed
	always_ff @(posedge clk) begin
		if (ctl.cap_key_i) begin
			key_i_q <= rd_key_q;
		end
	end

	// Element j precedes element i: smaller key, or equal key and lower index
	assign hit = ctl.cmp_en && ((rd_key_q < key_i_q) ||
		((rd_key_q == key_i_q) && (ctl.cmp_j < ctl.cur_i)));

	// Count preceding elements
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clr_cnt) begin
			cnt_q <= '0;
		end else if (ctl.cmp_en) begin
			cnt_q <= cnt_q + CNT_W'(hit);
		end
	end

	assign rank_pos = cnt_q + CNT_W'(hit);

endmodule

// ===== sv/msbp_emit.sv =====
module msbp_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msbp_pkg::emit_ctl_t  ctl,
	output logic                 idle,
	output logic                 result_valid,
	input  logic                 result_ready,
	output msbp_pkg::result_t    result
);
	import msbp_pkg::*;

	logic [ADDR_W-1:0] order_mem [MAX_ELEMENTS];
	logic [ADDR_W-1:0] rd_idx_q;
	logic              busy_q;
	logic              out_valid_q;
	logic              rd_pend_s1;
	logic [RANK_W-1:0] own_s1;
	logic              final_s1;
	logic [CNT_W-1:0]  p_q;
	logic [CNT_W-1:0]  c_q;
	logic [RANK_W-1:0] own_q;
	logic [CNT_W:0]    chunk_size;
	logic              chunk_end;
	logic              last_pos;
	logic              issue;
	result_t           result_q;

	// Order memory: sorted position -> arrival index
	always_ff @(posedge clk) begin
		if (ctl.ord_we) begin
			order_mem[ctl.ord_waddr] <= ctl.ord_wdata;
		end
		rd_idx_q <= order_mem[p_q[ADDR_W-1:0]];
	end

	// Chunk bookkeeping: the first rem chunks hold one extra element
	assign chunk_size = (own_q < ctl.rem) ? ({1'b0, ctl.per} + (CNT_W+1)'(1))
	                                      : {1'b0, ctl.per};
	assign chunk_end  = (({1'b0, c_q} + (CNT_W+1)'(1)) == chunk_size);
	assign last_pos   = (CNT_W'(p_q + CNT_W'(1)) == ctl.n);
	assign issue      = busy_q && !rd_pend_s1 && (!out_valid_q || result_ready);

	// Advance through sorted positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_pend_s1 <= 1'b0;
			p_q        <= '0;
			c_q        <= '0;
			own_q      <= '0;
		end else begin
			rd_pend_s1 <= issue;
			if (ctl.start) begin
				busy_q <= 1'b1;
				p_q    <= '0;
				c_q    <= '0;
				own_q  <= '0;
			end else if (issue) begin
				p_q <= p_q + CNT_W'(1);
				if (chunk_end) begin
					own_q <= own_q + RANK_W'(1);
					c_q   <= '0;
				end else begin
					c_q <= c_q + CNT_W'(1);
				end
				if (last_pos) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Carry rank and final mark alongside the memory read
	always_ff @(posedge clk) begin
		if (issue) begin
			own_s1   <= own_q;
			final_s1 <= last_pos;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			result_q.element_index <= IDX_W'(rd_idx_q);
			result_q.owner_rank    <= own_s1[IDX_W-1:0];
			result_q.local_hit     <= (own_s1[LRANK_W-1:0] == ctl.local_rank);
			result_q.final_item    <= final_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;
	assign idle         = !busy_q && !rd_pend_s1 && !out_valid_q;

endmodule

// ===== sv/morton_sort_block_partition.sv =====
// Loading: one key transaction per cycle while the set is open.
// After the closing key: a rank split (N / ranks by subtraction),
// then a rank-count sort over the key memory (one read per cycle).
// Emission: from the order memory while results are taken, one read pending at a time.
// Reset (arst_n low) empties the set and sets num_ranks to 1 and local_rank to 0;
// the memories need no clearing pass.
module morton_sort_block_partition (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  msbp_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output msbp_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [msbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [msbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import msbp_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic               count_inc;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   per_q;
	logic [RANK_W-1:0]  rem_q;
	logic [RANK_W-1:0]  num_ranks_q;
	logic [LRANK_W-1:0] local_rank_q;
	logic [RANK_W-1:0]  r_eff;
	logic               v_s1;
	logic [ADDR_W-1:0]  j_s1;
	logic               item_fire;
	logic               scan_done;
	logic               place_done;
	logic               emit_idle;
	logic [CNT_W-1:0]   rank_pos;
	rank_ctl_t          rank_ctl;
	emit_ctl_t          emit_ctl;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ranks_q  <= RANK_W'(1);
			local_rank_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_RANKS:  num_ranks_q  <= RANK_W'(cfg_data);
				CFG_LOCAL_RANK: local_rank_q <= cfg_data[LRANK_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp rank count to 1..64
	always_comb begin
		if (num_ranks_q == '0) begin
			r_eff = RANK_W'(1);
		end else if (num_ranks_q > RANK_W'(MAX_RANKS)) begin
			r_eff = RANK_W'(MAX_RANKS);
		end else begin
			r_eff = num_ranks_q;
		end
	end

	assign item_fire  = item_valid && item_ready;
	assign count_inc  = (count_q < CNT_W'(MAX_ELEMENTS));
	assign count_next = count_q + CNT_W'(count_inc);
	assign scan_done  = (CNT_W'(j_q + CNT_W'(1)) == count_q);
	assign place_done = (CNT_W'(i_q + CNT_W'(1)) == count_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (item_fire && item.last) state_d = ST_DIV;
			ST_DIV:   if (rem_q < r_eff) state_d = ST_RD_I;
			ST_RD_I:  state_d = ST_KEY_I;
			ST_KEY_I: state_d = ST_SCAN;
			ST_SCAN:  if (scan_done) state_d = ST_PLACE;
			ST_PLACE: state_d = place_done ? ST_EMIT : ST_RD_I;
			ST_EMIT:  if (emit_idle) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// FSM outputs
	always_comb begin
		item_ready         = (state_q == ST_LOAD);
		rank_ctl.key_we    = item_fire && count_inc;
		rank_ctl.key_waddr = count_q[ADDR_W-1:0];
		rank_ctl.key_wdata = item.sort_key;
		rank_ctl.key_raddr = (state_q == ST_RD_I) ? i_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];
		rank_ctl.cap_key_i = (state_q == ST_KEY_I);
		rank_ctl.clr_cnt   = (state_q == ST_KEY_I);
		rank_ctl.cmp_en    = v_s1;
		rank_ctl.cmp_j     = j_s1;
		rank_ctl.cur_i     = i_q[ADDR_W-1:0];
		emit_ctl.start      = (state_q == ST_PLACE) && place_done;
		emit_ctl.n          = count_q;
		emit_ctl.per        = per_q;
		emit_ctl.rem        = rem_q;
		emit_ctl.local_rank = local_rank_q;
		emit_ctl.ord_we     = (state_q == ST_PLACE);
		emit_ctl.ord_waddr  = rank_pos[ADDR_W-1:0];
		emit_ctl.ord_wdata  = i_q[ADDR_W-1:0];
	end

	// State, element count and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			per_q   <= '0;
			rem_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_SCAN);
			case (state_q)
				ST_LOAD: begin
					if (item_fire) begin
						count_q <= count_next;
						if (item.last) begin
							rem_q <= RANK_W'(count_next);
							per_q <= '0;
						end
					end
				end
				ST_DIV: begin
					if (rem_q >= r_eff) begin
						rem_q <= rem_q - r_eff;
						per_q <= per_q + CNT_W'(1);
					end else begin
						i_q <= '0;
					end
				end
				ST_KEY_I: j_q <= '0;
				ST_SCAN:  j_q <= j_q + CNT_W'(1);
				ST_PLACE: if (!place_done) i_q <= i_q + CNT_W'(1);
				ST_EMIT:  if (emit_idle) count_q <= '0;
				default: ;
			endcase
		end
	end

	// Index of the key now being read back
	always_ff @(posedge clk) begin
		j_s1 <= j_q[ADDR_W-1:0];
	end

	msbp_rank u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rank_ctl),
		.rank_pos (rank_pos)
	);

	msbp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (emit_ctl),
		.idle         (emit_idle),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Results appear only during emission
	a_result_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (state_q == ST_EMIT))
		else $error("result valid outside emission");

	// Element count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond store depth");

	// A sorted position always lies inside the set
	a_rank_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLACE) |-> (rank_pos < count_q))
		else $error("sorted position outside the set");

	// Loading never overlaps with a pending emission
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire |-> emit_idle)
		else $error("item accepted while results pending");

endmodule
